>>> hw/rtl/bb3_pkg.sv
// Shared types, widths and codes for the 3x3 edge-aware box blur.
// Used by every module of the block; depends on nothing.
package bb3_pkg;

    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 12;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COL_W_DEF    = 10;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = NUM_CH * CH_W;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int NUM_W  = SUM_W + 1;
    localparam int QBITS  = 8;
    localparam int QBIT_W = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // neighbor offsets: low is -1, mid is 0, high is +1
    localparam logic [1:0] TAP_LO  = 2'd0;
    localparam logic [1:0] TAP_MID = 2'd1;
    localparam logic [1:0] TAP_HI  = 2'd2;

    typedef enum logic [1:0] {
        G_IDLE,
        G_READ,
        G_DRAIN,
        G_HAND
    } t_gather_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } t_div_state;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]             count;
        logic                         last;
    } t_blur_job;

endpackage

>>> hw/rtl/bb3_line_mem.sv
// Line store: four rows of pixels, one write port and one registered read port.
// Depends on bb3_pkg for the default pixel width.
module bb3_line_mem #(
    parameter int ADDR_W = bb3_pkg::COL_W_DEF + 2,
    parameter int DATA_W = bb3_pkg::PIX_W
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);
    import bb3_pkg::*;

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/bb3_gather.sv
// Item sequencer: tracks frame positions, writes pixels to the line store and
// reads the nine neighbors of each due output. Depends on bb3_pkg.
module bb3_gather #(
    parameter int COL_W  = bb3_pkg::COL_W_DEF,
    parameter int ADDR_W = bb3_pkg::COL_W_DEF + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [bb3_pkg::WIDTH_W-1:0]  i_w_eff,
    input  logic [bb3_pkg::HEIGHT_W-1:0] i_h_eff,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [bb3_pkg::PIX_W-1:0]    i_pixel,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [bb3_pkg::PIX_W-1:0]    o_wr_data,
    output logic [ADDR_W-1:0]            o_rd_addr,
    input  logic [bb3_pkg::PIX_W-1:0]    i_rd_data,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output bb3_pkg::t_blur_job           o_job
);
    import bb3_pkg::*;

    localparam int CW     = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
    localparam int HW     = HEIGHT_W + 1;
    localparam int LEAD_W = WIDTH_W + 1;

    t_gather_state r_state, n_state;

    logic [COL_W-1:0]    r_in_col;
    logic [HEIGHT_W-1:0] r_in_row;
    logic                r_data_done;
    logic [LEAD_W-1:0]   r_lead, n_lead;
    logic [COL_W-1:0]    r_out_col;
    logic [HEIGHT_W-1:0] r_out_row;
    logic [1:0]          r_dr;
    logic [1:0]          r_dc;
    logic                r_rd_live;
    logic                r_rd_ok;
    logic [NUM_CH-1:0][SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]    r_cnt;

    logic              accept;
    logic              takes_pixel;
    logic              advance;
    logic              emit;
    logic [LEAD_W-1:0] lead_target;
    logic [CW-1:0]     in_col_inc;
    logic              in_col_wrap;
    logic              in_row_last;
    logic [CW-1:0]     out_col_inc;
    logic              out_col_wrap;
    logic              out_row_last;
    logic              out_last;
    logic              row_ok;
    logic              col_ok;
    logic              tap_last;
    logic              hand_done;
    logic [1:0]        rd_slot;
    logic [COL_W-1:0]  rd_col;

    // item bookkeeping
    always_comb begin
        accept      = i_in_valid && (r_state == G_IDLE);
        takes_pixel = !r_data_done && (i_opcode == OP_PIXEL);
        advance     = accept && (r_data_done || (i_opcode == OP_PIXEL));
        lead_target = LEAD_W'(i_w_eff) + LEAD_W'(2);
        n_lead      = (r_lead >= lead_target) ? r_lead : r_lead + LEAD_W'(1);
        emit        = advance && (n_lead >= lead_target);

        in_col_inc  = CW'(r_in_col) + CW'(1);
        in_col_wrap = in_col_inc >= CW'(i_w_eff);
        in_row_last = (HW'(r_in_row) + HW'(1)) >= HW'(i_h_eff);

        out_col_inc  = CW'(r_out_col) + CW'(1);
        out_col_wrap = out_col_inc >= CW'(i_w_eff);
        out_row_last = (HW'(r_out_row) + HW'(1)) >= HW'(i_h_eff);
        out_last     = out_row_last && out_col_wrap;

        tap_last  = (r_dr == TAP_HI) && (r_dc == TAP_HI);
        hand_done = (r_state == G_HAND) && i_job_ready;
    end

    // neighbor inside the frame?
    always_comb begin
        case (r_dr)
            TAP_LO:  row_ok = (r_out_row != '0);
            TAP_MID: row_ok = 1'b1;
            TAP_HI:  row_ok = !out_row_last;
            default: row_ok = 1'b0;
        endcase
        case (r_dc)
            TAP_LO:  col_ok = (r_out_col != '0);
            TAP_MID: col_ok = 1'b1;
            TAP_HI:  col_ok = !out_col_wrap;
            default: col_ok = 1'b0;
        endcase
        rd_slot = 2'(r_out_row[1:0] + r_dr - 2'd1);
        rd_col  = COL_W'(r_out_col + COL_W'(r_dc) - COL_W'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            G_IDLE:  if (emit) n_state = G_READ;
            G_READ:  if (tap_last) n_state = G_DRAIN;
            G_DRAIN: n_state = G_HAND;
            G_HAND:  if (i_job_ready) n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != G_IDLE);
        o_wr_en     = accept && takes_pixel;
        o_wr_addr   = {r_in_row[1:0], r_in_col};
        o_wr_data   = i_pixel;
        o_rd_addr   = {rd_slot, rd_col};
        o_job_valid = (r_state == G_HAND);
        o_job.sum   = r_sum;
        o_job.count = r_cnt;
        o_job.last  = out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= G_IDLE;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_data_done <= 1'b0;
            r_lead      <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_dr        <= TAP_LO;
            r_dc        <= TAP_LO;
            r_rd_live   <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_live <= (r_state == G_READ);
            r_rd_ok   <= row_ok && col_ok;

            if (advance) begin
                r_lead <= n_lead;
                if (takes_pixel) begin
                    r_in_col <= in_col_wrap ? '0 : COL_W'(in_col_inc);
                    if (in_col_wrap) begin
                        r_in_row <= r_in_row + HEIGHT_W'(1);
                        if (in_row_last) r_data_done <= 1'b1;
                    end
                end
            end

            // walk the taps row by row
            if (emit) begin
                r_dr <= TAP_LO;
                r_dc <= TAP_LO;
            end else if (r_state == G_READ) begin
                if (r_dc == TAP_HI) begin
                    r_dc <= TAP_LO;
                    r_dr <= r_dr + 2'd1;
                end else begin
                    r_dc <= r_dc + 2'd1;
                end
            end

            if (hand_done) begin
                if (out_last) begin
                    r_in_col    <= '0;
                    r_in_row    <= '0;
                    r_data_done <= 1'b0;
                    r_lead      <= '0;
                    r_out_col   <= '0;
                    r_out_row   <= '0;
                end else begin
                    r_out_col <= out_col_wrap ? '0 : COL_W'(out_col_inc);
                    if (out_col_wrap) r_out_row <= r_out_row + HEIGHT_W'(1);
                end
            end

            if (i_restart) begin
                r_in_col    <= '0;
                r_in_row    <= '0;
                r_data_done <= 1'b0;
                r_lead      <= '0;
                r_out_col   <= '0;
                r_out_row   <= '0;
            end
        end
    end

    // accumulate the in-frame neighbors as they return
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_rd_live && r_rd_ok) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_sum[ch] <= r_sum[ch] + SUM_W'(i_rd_data[ch*CH_W +: CH_W]);
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

endmodule

>>> hw/rtl/bb3_div.sv
// Rounded mean unit: restoring divide of (2*sum+count) by 2*count, one quotient
// bit per cycle for all three channels, plus the output register. Uses bb3_pkg.
module bb3_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    output logic                           o_job_ready,
    input  bb3_pkg::t_blur_job             i_job,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bb3_pkg::CH_W-1:0]       o_red,
    output logic [bb3_pkg::CH_W-1:0]       o_green,
    output logic [bb3_pkg::CH_W-1:0]       o_blue,
    output logic                           o_last
);
    import bb3_pkg::*;

    t_div_state r_state, n_state;

    logic [QBIT_W-1:0]             r_bit;
    logic [NUM_W-1:0]              r_dsh;
    logic [NUM_CH-1:0][NUM_W-1:0]  r_rem;
    logic [NUM_CH-1:0][QBITS-1:0]  r_quo;
    logic                          r_last;
    logic                          r_out_valid;
    logic [NUM_CH-1:0][CH_W-1:0]   r_out_pix;
    logic                          r_out_last;

    logic                          start;
    logic                          out_free;
    logic                          load_out;
    logic [NUM_CH-1:0]             fits;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            fits[ch] = (r_rem[ch] >= r_dsh);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: if (i_job_valid) n_state = DIV_RUN;
            DIV_RUN:  if (r_bit == '0) n_state = DIV_HOLD;
            DIV_HOLD: if (out_free) n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        start       = (r_state == DIV_IDLE) && i_job_valid;
        load_out    = (r_state == DIV_HOLD) && out_free;
        o_job_ready = (r_state == DIV_IDLE);
        o_out_valid = r_out_valid;
        o_red       = r_out_pix[2];
        o_green     = r_out_pix[1];
        o_blue      = r_out_pix[0];
        o_last      = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DIV_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_bit <= QBIT_W'(QBITS - 1);
            end else if (r_state == DIV_RUN) begin
                r_bit <= r_bit - QBIT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_dsh  <= NUM_W'({i_job.count, 1'b0}) << (QBITS - 1);
            r_last <= i_job.last;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_rem[ch] <= NUM_W'({i_job.sum[ch], 1'b0}) + NUM_W'(i_job.count);
                r_quo[ch] <= '0;
            end
        end else if (r_state == DIV_RUN) begin
            r_dsh <= r_dsh >> 1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (fits[ch]) r_rem[ch] <= r_rem[ch] - r_dsh;
                r_quo[ch] <= {r_quo[ch][QBITS-2:0], fits[ch]};
            end
        end
        if (load_out) begin
            r_out_pix  <= r_quo;
            r_out_last <= r_last;
        end
    end

endmodule

>>> hw/rtl/box_blur_3x3_edge_aware_core.sv
// 3x3 edge-aware box blur core: RGB pixels in raster order, blurred pixels out.
// Items that yield no result are taken without a stall. An item that yields a result
// stalls the input while its nine neighbor reads go through the single read port
// of the line store. A result passes through the reads, the handoff, the eight-step
// divide and the output register. Synchronous active-low reset clears all
// control state; the line store is not cleared and needs no clearing pass.
module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beats
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [bb3_pkg::CH_W-1:0]       i_red_in,
    input  logic [bb3_pkg::CH_W-1:0]       i_green_in,
    input  logic [bb3_pkg::CH_W-1:0]       i_blue_in,
    // result beats
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bb3_pkg::CH_W-1:0]       o_red_out,
    output logic [bb3_pkg::CH_W-1:0]       o_green_out,
    output logic [bb3_pkg::CH_W-1:0]       o_blue_out,
    output logic                           o_frame_last,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bb3_pkg::*;

    // column index covers MAX_WIDTH; the store keeps four rows, row r in slot r mod 4
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ADDR_W = COL_W + 2;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                cfg_write;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              job_valid;
    logic              job_ready;
    t_blur_job         job;

    // Configuration is always taken; any write abandons the frame in progress.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(WIDTH_RESET);
            r_height <= HEIGHT_W'(HEIGHT_RESET);
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size: zero width or height acts as one, width above the
    // store's row length acts as the row length.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    // Sequencer: write each pixel, then once an output's window is complete
    // read its nine neighbors and sum those inside the frame.
    bb3_gather #(
        .COL_W  (COL_W),
        .ADDR_W (ADDR_W)
    ) u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_write),
        .i_w_eff     (w_eff),
        .i_h_eff     (h_eff),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_pixel     ({i_red_in, i_green_in, i_blue_in}),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    bb3_line_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Divider overlaps the next item's reads; its output register holds a
    // finished beat while the sequencer moves on.
    bb3_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out),
        .o_last      (o_frame_last)
    );

endmodule
